// ===== hdl/tmrb_pkg.sv =====
// Package for the periodic and one-shot timer bank.
// Holds the default sizes, the operation codes and the item and control structs.
// Used by the interfaces, the slot cell and the top level; depends on nothing.
package tmrb_pkg;

  // Default sizes of the bank.
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned TIME_BITS = 32;

  // Fixed field widths of the items.
  localparam int unsigned OpW    = 2;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned FieldW = 32;
  localparam int unsigned MaskW  = 8;

  // Operation codes carried by an input item.
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // One input item.
  typedef struct packed {
    op_e               operation;
    logic [SlotW-1:0]  slot;
    logic [FieldW-1:0] interval_value;
    logic              repeat_flag;
    logic [FieldW-1:0] elapsed;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [MaskW-1:0]  fired_mask;
    logic              any_fired;
    logic              next_valid;
    logic [FieldW-1:0] next_remaining;
  } out_item_t;

  // Control part of an item as it travels down the row of cells.
  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [SlotW-1:0] slot;
    logic             rep;
    logic [MaskW-1:0] mask;
    logic             any;
    logic             found;
  } ctrl_t;

endpackage

// ===== hdl/tmrb_in_if.sv =====
// Input channel of the timer bank: valid, ready and one input item.
// Depends on tmrb_pkg for the item struct.
interface tmrb_in_if;
  logic               valid;
  logic               ready;
  tmrb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tmrb_out_if.sv =====
// Output channel of the timer bank: valid, ready and one result item.
// Depends on tmrb_pkg for the item struct.
interface tmrb_out_if;
  logic                valid;
  logic                ready;
  tmrb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tmrb_cell.sv =====
// One timer slot cell: holds the slot state and one stage of the traveling item.
// Depends on tmrb_pkg for the operation codes and the control struct.
module tmrb_cell #(
  parameter int unsigned Idx      = 0,
  parameter int unsigned TimeBits = tmrb_pkg::TIME_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  tmrb_pkg::ctrl_t     ctrl_i,
  input  logic [TimeBits-1:0] ival_i,
  input  logic [TimeBits-1:0] elap_i,
  input  logic [TimeBits-1:0] least_i,
  output tmrb_pkg::ctrl_t     ctrl_o,
  output logic [TimeBits-1:0] ival_o,
  output logic [TimeBits-1:0] elap_o,
  output logic [TimeBits-1:0] least_o
);

  // Slot state.
  logic                active_q, active_d;
  logic                rep_q, rep_d;
  logic [TimeBits-1:0] rem_q, rem_d;
  logic [TimeBits-1:0] int_q, int_d;

  // Stage register toward the next cell.
  tmrb_pkg::ctrl_t     ctrl_q, ctrl_d;
  logic [TimeBits-1:0] ival_q, elap_q, least_q, least_d;

  logic hit;
  logic fire;
  logic take;

  assign hit = (32'(ctrl_i.slot) == Idx);

  // Apply the operation to this slot.
  always_comb begin
    active_d = active_q;
    rep_d    = rep_q;
    rem_d    = rem_q;
    int_d    = int_q;
    fire     = 1'b0;
    unique case (ctrl_i.op)
      tmrb_pkg::OP_TICK: begin
        if (active_q) begin
          if (rem_q > elap_i) begin
            rem_d = rem_q - elap_i;
          end else begin
            // Fired: reload the interval, and a one-shot slot ends.
            fire     = 1'b1;
            rem_d    = int_q;
            active_d = rep_q;
          end
        end
      end
      tmrb_pkg::OP_ARM: begin
        if (hit) begin
          int_d    = ival_i;
          rem_d    = ival_i;
          rep_d    = ctrl_i.rep;
          active_d = 1'b1;
        end
      end
      tmrb_pkg::OP_DISARM: begin
        if (hit) begin
          active_d = 1'b0;
        end
      end
      tmrb_pkg::OP_CLEAR: begin
        active_d = 1'b0;
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  // Fold this slot into the fired mask and the running minimum.
  always_comb begin
    take         = active_d && (!ctrl_i.found || (rem_d < least_i));
    least_d      = take ? rem_d : least_i;
    ctrl_d       = ctrl_i;
    ctrl_d.mask  = ctrl_i.mask | (tmrb_pkg::MaskW'(fire) << Idx);
    ctrl_d.any   = ctrl_i.any | fire;
    ctrl_d.found = ctrl_i.found | active_d;
  end

  // Active mark, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (adv_i && ctrl_i.vld) begin
      active_q <= active_d;
    end
  end

  // Slot payload, meaningful only while the slot is active.
  always_ff @(posedge clk_i) begin
    if (adv_i && ctrl_i.vld) begin
      rep_q <= rep_d;
      rem_q <= rem_d;
      int_q <= int_d;
    end
  end

  // Stage control, with the valid bit cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ival_q  <= ival_i;
      elap_q  <= elap_i;
      least_q <= least_d;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign ival_o  = ival_q;
  assign elap_o  = elap_q;
  assign least_o = least_q;

endmodule

// ===== hdl/periodic_oneshot_timer_bank.sv =====
// Periodic and one-shot timer bank built as a row of slot cells.
// An accepted item passes through the stage register of each cell in turn to its result.
// Throughput: one item per cycle while the output is not stalled, as each item walks the row one cell behind the last.
// The last cell's stage register is the output register; a stalled output holds the row.
// Reset (rst_ni low, asynchronous) clears every active mark and every stage valid bit.
// Depends on tmrb_pkg, tmrb_in_if, tmrb_out_if and tmrb_cell.
module periodic_oneshot_timer_bank #(
  parameter int unsigned NumSlots = tmrb_pkg::NUM_SLOTS,
  parameter int unsigned TimeBits = tmrb_pkg::TIME_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmrb_in_if.sink    in_i,
  tmrb_out_if.source out_o
);

  tmrb_pkg::ctrl_t     ctrl_s  [NumSlots+1];
  logic [TimeBits-1:0] ival_s  [NumSlots+1];
  logic [TimeBits-1:0] elap_s  [NumSlots+1];
  logic [TimeBits-1:0] least_s [NumSlots+1];
  logic                adv;

  // The whole row moves unless a finished result is still waiting.
  assign adv        = !ctrl_s[NumSlots].vld || out_o.ready;
  assign in_i.ready = adv;

  // Entry of an item into the first cell.
  always_comb begin
    ctrl_s[0].vld   = in_i.valid && adv;
    ctrl_s[0].op    = in_i.data.operation;
    ctrl_s[0].slot  = in_i.data.slot;
    ctrl_s[0].rep   = in_i.data.repeat_flag;
    ctrl_s[0].mask  = '0;
    ctrl_s[0].any   = 1'b0;
    ctrl_s[0].found = 1'b0;
    ival_s[0]       = TimeBits'(in_i.data.interval_value);
    elap_s[0]       = TimeBits'(in_i.data.elapsed);
    least_s[0]      = '0;
  end

  // Row of slot cells.
  for (genvar g = 0; g < NumSlots; g++) begin : g_cell
    tmrb_cell #(
      .Idx      (g),
      .TimeBits (TimeBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .ctrl_i  (ctrl_s[g]),
      .ival_i  (ival_s[g]),
      .elap_i  (elap_s[g]),
      .least_i (least_s[g]),
      .ctrl_o  (ctrl_s[g+1]),
      .ival_o  (ival_s[g+1]),
      .elap_o  (elap_s[g+1]),
      .least_o (least_s[g+1])
    );
  end

  // Result item from the last cell.
  assign out_o.valid               = ctrl_s[NumSlots].vld;
  assign out_o.data.fired_mask     = ctrl_s[NumSlots].mask;
  assign out_o.data.any_fired      = ctrl_s[NumSlots].any;
  assign out_o.data.next_valid     = ctrl_s[NumSlots].found;
  assign out_o.data.next_remaining = ctrl_s[NumSlots].found ?
                                     tmrb_pkg::FieldW'(least_s[NumSlots]) : '0;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for periodic_oneshot_timer_bank: directed and random tick, arm,
// disarm and clear items, with random gaps on the input and stalls on the output side.
// Depends on tmrb_pkg, tmrb_in_if, tmrb_out_if and the timer bank RTL.
module tb_top;

  localparam int unsigned NumSlots   = tmrb_pkg::NUM_SLOTS;
  localparam int unsigned RandItems  = 1625;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned DrainWait  = 2 * tmrb_pkg::NUM_SLOTS + 4;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmrb_in_if  item_in ();
  tmrb_out_if result_out ();

  periodic_oneshot_timer_bank u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_in),
    .out_o  (result_out)
  );

  // Clock with a period of 10 time units.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the slot bank.
  logic                        slot_on     [NumSlots];
  logic [tmrb_pkg::FieldW-1:0] slot_left   [NumSlots];
  logic [tmrb_pkg::FieldW-1:0] slot_period [NumSlots];
  logic                        slot_rep    [NumSlots];

  tmrb_pkg::in_item_t  stim_items [$];
  tmrb_pkg::out_item_t due_results [$];

  int unsigned total_items;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_fire_results;
  int unsigned n_errors;
  int unsigned op_count [4];

  logic item_taken;
  int   in_gap;
  int   out_stall;
  int   phase_cnt;
  logic quiet_run;

  // Applies one item to the predicted bank and returns the result it should produce.
  function automatic tmrb_pkg::out_item_t bank_step(tmrb_pkg::in_item_t it);
    tmrb_pkg::out_item_t res;
    res = '0;
    case (it.operation)
      tmrb_pkg::OP_TICK: begin
        for (int s = 0; s < NumSlots; s++) begin
          if (slot_on[s]) begin
            if (slot_left[s] > it.elapsed) begin
              slot_left[s] = slot_left[s] - it.elapsed;
            end else begin
              // Fired: reload the full interval, overshoot is dropped.
              if (s < tmrb_pkg::MaskW) res.fired_mask[s] = 1'b1;
              res.any_fired = 1'b1;
              slot_left[s]  = slot_period[s];
              if (!slot_rep[s]) slot_on[s] = 1'b0;
            end
          end
        end
      end
      tmrb_pkg::OP_ARM: begin
        if (it.slot < NumSlots) begin
          slot_period[it.slot] = it.interval_value;
          slot_left[it.slot]   = it.interval_value;
          slot_rep[it.slot]    = it.repeat_flag;
          slot_on[it.slot]     = 1'b1;
        end
      end
      tmrb_pkg::OP_DISARM: begin
        if (it.slot < NumSlots) slot_on[it.slot] = 1'b0;
      end
      tmrb_pkg::OP_CLEAR: begin
        for (int s = 0; s < NumSlots; s++) slot_on[s] = 1'b0;
      end
      default: begin
      end
    endcase
    // Least remaining time over the slots still active.
    for (int s = 0; s < NumSlots; s++) begin
      if (slot_on[s]) begin
        if (!res.next_valid || slot_left[s] < res.next_remaining) begin
          res.next_remaining = slot_left[s];
        end
        res.next_valid = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Gap length: mostly none or short, a few long, none at all during a quiet run.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [tmrb_pkg::FieldW-1:0] rand_interval();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return '0;
    if (r < 10) return $urandom_range(1, 64);
    if (r < 14) return $urandom_range(65, 5000);
    if (r == 14) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [tmrb_pkg::FieldW-1:0] rand_elapsed();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return '0;
    if (r < 12) return $urandom_range(1, 40);
    if (r < 15) return $urandom_range(41, 3000);
    return $urandom;
  endfunction

  task automatic push_item(tmrb_pkg::op_e op, logic [tmrb_pkg::SlotW-1:0] slot,
                           logic [tmrb_pkg::FieldW-1:0] ival, logic rep,
                           logic [tmrb_pkg::FieldW-1:0] el);
    tmrb_pkg::in_item_t it;
    it.operation      = op;
    it.slot           = slot;
    it.interval_value = ival;
    it.repeat_flag    = rep;
    it.elapsed        = el;
    stim_items = {stim_items, it};
  endtask

  // Input driver: holds an item until it is taken, then inserts a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!item_in.valid || item_taken) begin
        if (in_gap > 0) begin
          item_in.valid <= 1'b0;
          in_gap--;
        end else if (stim_items.size() != 0) begin
          item_in.valid <= 1'b1;
          item_in.data  <= stim_items.pop_front();
          in_gap = pick_gap();
        end else begin
          item_in.valid <= 1'b0;
        end
      end
    end
  end

  // Output stalls, with an occasional quiet run of no gaps on either side.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      phase_cnt++;
      if (phase_cnt % 128 == 0) quiet_run = ($urandom_range(0, 3) == 0);
      if (out_stall > 0) begin
        result_out.ready <= 1'b0;
        out_stall--;
      end else begin
        result_out.ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Monitor: predicts on each accepted item and checks each accepted result.
  always @(posedge clk_i) begin
    tmrb_pkg::out_item_t want;
    tmrb_pkg::out_item_t got;
    item_taken <= rst_ni && item_in.valid && item_in.ready;
    if (rst_ni && item_in.valid && item_in.ready) begin
      due_results = {due_results, bank_step(item_in.data)};
      op_count[item_in.data.operation]++;
      n_accepted++;
    end
    if (rst_ni && result_out.valid && result_out.ready) begin
      got = result_out.data;
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, actual %0h", $time, got);
      end else begin
        want = due_results.pop_front();
        check_field("fired_mask", 32'(want.fired_mask), 32'(got.fired_mask));
        check_field("any_fired", 32'(want.any_fired), 32'(got.any_fired));
        check_field("next_valid", 32'(want.next_valid), 32'(got.next_valid));
        check_field("next_remaining", want.next_remaining, got.next_remaining);
        if (want.any_fired) n_fire_results++;
        n_checked++;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((item_in.valid && item_in.ready) || (result_out.valid && result_out.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
    $display("** periodic_oneshot_timer_bank: FAILED **");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    tmrb_pkg::op_e rop;
    int            r;
    rst_ni           = 1'b0;
    item_in.valid    = 1'b0;
    item_in.data     = '0;
    result_out.ready = 1'b0;
    item_taken       = 1'b0;
    in_gap           = 0;
    out_stall        = 0;
    phase_cnt        = 0;
    quiet_run        = 1'b0;
    n_accepted       = 0;
    n_checked        = 0;
    n_fire_results   = 0;
    n_errors         = 0;
    foreach (op_count[i]) op_count[i] = 0;
    for (int s = 0; s < NumSlots; s++) begin
      slot_on[s]     = 1'b0;
      slot_left[s]   = '0;
      slot_period[s] = '0;
      slot_rep[s]    = 1'b0;
    end

    // Directed part: empty bank, extreme times, zero interval, re-arm,
    // exact expiry, disarm of an idle slot, and clear.
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_TICK,   3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(tmrb_pkg::OP_ARM,    3'd0, '0, 1'b1, '0);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_ARM,    3'd7, 32'hFFFF_FFFF, 1'b0, '0);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'hFFFF_FFFE);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'd1);
    push_item(tmrb_pkg::OP_DISARM, 3'd7, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_ARM,    3'd3, 32'd100, 1'b1, '0);
    push_item(tmrb_pkg::OP_ARM,    3'd3, 32'd50, 1'b0, '0);
    push_item(tmrb_pkg::OP_ARM,    3'd5, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'd10);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'd40);
    push_item(tmrb_pkg::OP_ARM,    3'd1, 32'd10, 1'b1, '0);
    push_item(tmrb_pkg::OP_ARM,    3'd2, 32'd7, 1'b1, '0);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'd3);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'hFFFF_FFFF);
    push_item(tmrb_pkg::OP_DISARM, 3'd0, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_DISARM, 3'd1, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_CLEAR,  3'd0, '0, 1'b0, '0);
    push_item(tmrb_pkg::OP_TICK,   3'd0, '0, 1'b0, 32'd5);
    push_item(tmrb_pkg::OP_ARM,    3'd4, 32'h8000_0000, 1'b1, '0);
    push_item(tmrb_pkg::OP_ARM,    3'd6, 32'h7FFF_FFFF, 1'b0, '0);
    push_item(tmrb_pkg::OP_CLEAR,  3'd5, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(tmrb_pkg::OP_DISARM, 3'd2, '0, 1'b0, '0);

    // Random part: ticks and arms dominate so slots stay busy and fire often;
    // unused fields carry random noise.
    for (int n = 0; n < RandItems; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) rop = tmrb_pkg::OP_TICK;
      else if (r < 80) rop = tmrb_pkg::OP_ARM;
      else if (r < 96) rop = tmrb_pkg::OP_DISARM;
      else rop = tmrb_pkg::OP_CLEAR;
      push_item(rop, tmrb_pkg::SlotW'($urandom_range(0, NumSlots - 1)), rand_interval(),
                1'($urandom_range(0, 1)), rand_elapsed());
    end
    total_items = stim_items.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < total_items) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (due_results.size() != 0) n_errors++;

    $display("Covered %0d items: %0d ticks, %0d arms, %0d disarms, %0d clears.",
             n_accepted, op_count[tmrb_pkg::OP_TICK], op_count[tmrb_pkg::OP_ARM],
             op_count[tmrb_pkg::OP_DISARM], op_count[tmrb_pkg::OP_CLEAR]);
    $display("Checked %0d results, %0d with fired slots; %0d errors.",
             n_checked, n_fire_results, n_errors);
    if (n_errors == 0) begin
      $display("** periodic_oneshot_timer_bank: PASSED **");
    end else begin
      $display("** periodic_oneshot_timer_bank: FAILED **");
    end
    $finish;
  end

endmodule
